// ===== rtl/xbrg_pkg.sv =====
package xbrg_pkg;

  // Request codes carried in the req_type field.
  localparam logic [1:0] REQ_RAW     = 2'd0;
  localparam logic [1:0] REQ_BOUNDED = 2'd1;
  localparam logic [1:0] REQ_FRAC    = 2'd2;

  // Base added to the seed when the state words are loaded.
  localparam logic [31:0] SEED_BASE = 32'd12345678;

  // Fraction requests keep the top bits of a word.
  localparam int unsigned FRAC_SHIFT = 11;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] limit;
  } xbrg_req_t;

  typedef struct packed {
    logic [63:0] value;
    logic        error;
  } xbrg_rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } xbrg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
    logic seed_load;
    logic rsp_load;
  } xbrg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_limit;
    logic reject;
  } xbrg_status_t;

endpackage

// ===== rtl/xoshiro_bounded_random_generator_top.sv =====
// xoshiro256** generator with raw, bounded and unit-fraction requests.
// Request channel: req_valid/req_stall carry req_type and limit; a request is
// taken at a rising edge with req_valid high and req_stall low.
// Result channel: rsp_valid/rsp_stall carry value and error, one per request.
// Seed channel: cfg_valid/cfg_ready write the 32-bit seed, which reloads the
// four state words; write it only while no request is in flight.
// A raw or fraction request loads its result from the draw state: the accepting
// edge steps the state and forms s1*5, and the draw state finishes the
// scramble and loads the result once the result register is free.
// A bounded draw steps the state again for each rejected try, since each try
// is one step of the same state update; on average it needs under two tries.
// A bounded draw with limit zero returns value 0 and error 1 from the draw
// state without stepping the state.
// A new request is taken only after the previous one has loaded its result.
// Reset loads the state as a seed of zero and drops any pending result.
// While the receiver stalls, the result register holds its value; the block
// finishes the next request and waits with it until the register frees.
module xoshiro_bounded_random_generator_top import xbrg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  xbrg_req_t   req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output xbrg_rsp_t   rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  xbrg_cmd_t    cmd;
  xbrg_status_t status;
  xbrg_state_t  state;

  xbrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .cfg_valid (cfg_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .req_stall (req_stall),
    .cfg_ready (cfg_ready),
    .rsp_valid (rsp_valid),
    .cmd       (cmd),
    .state     (state)
  );

  xbrg_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .rsp      (rsp)
  );

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_DRAW))
    else $error("request accepted but no draw in progress");

  // A seed write and a request are never taken together.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !(req_valid && !req_stall))
    else $error("seed write and request taken in the same cycle");

  // An error result always carries a zero value.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.error) |-> (rsp.value == 64'd0))
    else $error("error result with nonzero value");

  // A result is only loaded from the draw state.
  assert property (@(posedge clk) disable iff (rst)
    cmd.rsp_load |-> (state == ST_DRAW) && !status.reject)
    else $error("result loaded outside a finished draw");

endmodule

// ===== rtl/xbrg_datapath.sv =====
module xbrg_datapath import xbrg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  xbrg_req_t    req,
  input  logic [31:0]  cfg_data,
  input  xbrg_cmd_t    cmd,
  output xbrg_status_t status,
  output xbrg_rsp_t    rsp
);

  logic [63:0] gen_state [4];
  logic [63:0] gen_state_next [4];
  logic [63:0] w5;
  logic [1:0]  req_type;
  logic [63:0] limit;
  logic [63:0] mask;
  logic        err;
  logic [63:0] mask_next;
  logic [63:0] rot;
  logic [63:0] word;
  logic [63:0] masked;
  logic [63:0] t2;
  logic [63:0] t3;
  logic [63:0] result_value;

  // One xoshiro256** state update.
  always_comb begin
    t2 = gen_state[2] ^ gen_state[0];
    t3 = gen_state[3] ^ gen_state[1];
    gen_state_next[0] = gen_state[0] ^ t3;
    gen_state_next[1] = gen_state[1] ^ t2;
    gen_state_next[2] = t2 ^ (gen_state[1] << 17);
    gen_state_next[3] = {t3[18:0], t3[63:19]};
  end

  // The mask covers every bit up to the highest set bit of the limit.
  always_comb begin
    mask_next = req.limit;
    for (int k = 0; k < 6; k++) begin
      mask_next = mask_next | (mask_next >> (1 << k));
    end
  end

  // State words, seed loads and the first half of the output scramble.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        gen_state[i] <= {32'd0, SEED_BASE + 32'(i)};
      end
    end else if (cmd.seed_load) begin
      for (int i = 0; i < 4; i++) begin
        gen_state[i] <= {32'd0, SEED_BASE + cfg_data + 32'(i)};
      end
    end else if (cmd.step) begin
      gen_state <= gen_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      w5 <= gen_state[1] + (gen_state[1] << 2);
    end
  end

  // Request fields held for the whole draw.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type <= req.req_type;
      limit    <= req.limit;
      mask     <= mask_next;
      err      <= (req.req_type == REQ_BOUNDED) && (req.limit == 64'd0);
    end
  end

  // Second half of the scramble: rotate by 7, then multiply by 9.
  assign rot    = {w5[56:0], w5[63:57]};
  assign word   = rot + (rot << 3);
  assign masked = word & mask;

  always_comb begin
    case (req_type)
      REQ_BOUNDED: result_value = err ? 64'd0 : masked;
      REQ_FRAC:    result_value = word >> FRAC_SHIFT;
      default:     result_value = word;
    endcase
  end

  assign status.zero_limit = (req.req_type == REQ_BOUNDED) && (req.limit == 64'd0);
  assign status.reject     = (req_type == REQ_BOUNDED) && !err && (masked >= limit);

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp.value <= result_value;
      rsp.error <= err;
    end
  end

endmodule

// ===== rtl/xbrg_ctrl.sv =====
module xbrg_ctrl import xbrg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         cfg_valid,
  input  logic         rsp_stall,
  input  xbrg_status_t status,
  output logic         req_stall,
  output logic         cfg_ready,
  output logic         rsp_valid,
  output xbrg_cmd_t    cmd,
  output xbrg_state_t  state
);

  xbrg_state_t state_next;
  logic        rsp_free;

  assign rsp_free = !rsp_valid || !rsp_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid && !cfg_valid) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (!status.reject && rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    cfg_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        cfg_ready     = 1'b1;
        req_stall     = cfg_valid;
        cmd.seed_load = cfg_valid;
        cmd.accept    = req_valid && !cfg_valid;
        cmd.step      = req_valid && !cfg_valid && !status.zero_limit;
      end
      ST_DRAW: begin
        cmd.step     = status.reject;
        cmd.rsp_load = !status.reject && rsp_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // The result stays valid until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
